### hw/rtl/ntl_pkg.sv
// Shared types, codes and control structs for the name table core.
package ntl_pkg;

  localparam int SLOT_W = 6;
  localparam int KEY_W  = 64;

  typedef logic [1:0] func_t;

  localparam func_t FUNC_CREATE = 2'd0;
  localparam func_t FUNC_DELETE = 2'd1;
  localparam func_t FUNC_LIST   = 2'd2;
  localparam func_t FUNC_RSVD   = 2'd3;

  typedef enum logic [2:0] {
    ST_CREATED,
    ST_EXISTS,
    ST_FULL,
    ST_DELETED,
    ST_NOTFOUND,
    ST_ENTRY,
    ST_EMPTY
  } status_t;

  typedef struct packed {
    func_t             func;
    logic [KEY_W-1:0]  key;
  } cmd_word_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [KEY_W-1:0]  entry_key;
    logic              last;
  } rsp_word_t;

  typedef enum logic [1:0] {
    SLOT_ZERO,
    SLOT_IDX,
    SLOT_FREE
  } slot_src_t;

  typedef enum logic [1:0] {
    KEY_ZERO,
    KEY_CMD,
    KEY_RAM
  } key_src_t;

  // controller to datapath
  typedef struct packed {
    logic      load;
    logic      rd;
    logic      adv;
    logic      note_free;
    logic      wr_new;
    logic      clr_used;
    logic      emit;
    status_t   emit_status;
    slot_src_t slot_src;
    key_src_t  key_src;
    logic      emit_last;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    func_t func;
    logic  used_here;
    logic  idx_last;
    logic  match;
    logic  more_above;
    logic  free_found;
    logic  out_free;
  } sts_t;

endpackage

### hw/rtl/ntl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ntl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // hold read data while re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/ntl_dpath.sv
// Datapath: command registers, slot scan counter, used marks, key RAM, result register.
module ntl_dpath #(
  parameter int SLOTS     = 64,
  parameter int KEY_BYTES = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  ntl_pkg::cmd_word_t cmd_word,
  input  ntl_pkg::ctl_t     ctl,
  output ntl_pkg::sts_t     sts,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output ntl_pkg::rsp_word_t rsp_word
);
  import ntl_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int KW = 8 * KEY_BYTES;

  func_t          func;
  logic [KW-1:0]  key;
  logic [IW-1:0]  idx;
  logic [IW-1:0]  free_idx;
  logic           free_found;
  logic [SLOTS-1:0] used;
  logic [SLOTS-1:0] above;
  logic [KW-1:0]  rdata;
  logic [SLOT_W-1:0] slot_sel;
  logic [KEY_W-1:0]  key_sel;

  ntl_ram #(
    .WIDTH(KW),
    .DEPTH(SLOTS)
  ) u_keys (
    .clk  (clk),
    .we   (ctl.wr_new),
    .waddr(free_idx),
    .wdata(key),
    .re   (ctl.rd),
    .raddr(idx),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      func <= cmd_word.func;
      key  <= cmd_word.key[KW-1:0];
    end
    if (ctl.note_free) begin
      free_idx <= idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      free_found <= 1'b0;
      used       <= '0;
    end else begin
      if (ctl.load) begin
        idx        <= '0;
        free_found <= 1'b0;
      end else if (ctl.adv) begin
        idx <= idx + IW'(1);
      end
      if (ctl.note_free) begin
        free_found <= 1'b1;
      end
      if (ctl.wr_new) begin
        used[free_idx] <= 1'b1;
      end
      if (ctl.clr_used) begin
        used[idx] <= 1'b0;
      end
    end
  end

  // used slots beyond the current one decide the list's final word
  always_comb begin
    above = '0;
    for (int j = 0; j < SLOTS; j++) begin
      above[j] = used[j] && (j > int'(idx));
    end
  end

  always_comb begin
    unique case (ctl.slot_src)
      SLOT_IDX:  slot_sel = SLOT_W'(idx);
      SLOT_FREE: slot_sel = SLOT_W'(free_idx);
      default:   slot_sel = '0;
    endcase
    unique case (ctl.key_src)
      KEY_CMD: key_sel = KEY_W'(key);
      KEY_RAM: key_sel = KEY_W'(rdata);
      default: key_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      rsp_word.status    <= ctl.emit_status;
      rsp_word.slot      <= slot_sel;
      rsp_word.entry_key <= key_sel;
      rsp_word.last      <= ctl.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  assign sts.func       = func;
  assign sts.used_here  = used[idx];
  assign sts.idx_last   = (int'(idx) == SLOTS - 1);
  assign sts.match      = (rdata == key);
  assign sts.more_above = |above;
  assign sts.free_found = free_found;
  assign sts.out_free   = !rsp_valid || !rsp_stall;

  assert property (@(posedge clk) disable iff (rst) ctl.wr_new |-> !used[free_idx])
    else $error("new key written into a slot that is already used");
  assert property (@(posedge clk) disable iff (rst) ctl.clr_used |-> used[idx])
    else $error("delete clears a slot that is not used");

endmodule

### hw/rtl/ntl_ctrl.sv
// Controller: sequences the slot scan and the emission of result words.
module ntl_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          busy,
  input  ntl_pkg::sts_t sts,
  output ntl_pkg::ctl_t ctl
);
  import ntl_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    ctl        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          ctl.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.func == FUNC_RSVD) begin
          state_next = S_IDLE;
        end else if (sts.used_here) begin
          ctl.rd     = 1'b1;
          state_next = S_CHECK;
        end else begin
          ctl.note_free = (sts.func == FUNC_CREATE) && !sts.free_found;
          if (sts.idx_last) begin
            state_next = S_FINISH;
          end else begin
            ctl.adv = 1'b1;
          end
        end
      end
      S_CHECK: begin
        if (sts.func == FUNC_LIST) begin
          if (sts.out_free) begin
            ctl.emit        = 1'b1;
            ctl.emit_status = ST_ENTRY;
            ctl.slot_src    = SLOT_IDX;
            ctl.key_src     = KEY_RAM;
            ctl.emit_last   = !sts.more_above;
            if (sts.more_above) begin
              ctl.adv    = 1'b1;
              state_next = S_SCAN;
            end else begin
              state_next = S_IDLE;
            end
          end
        end else if (sts.match) begin
          if (sts.out_free) begin
            ctl.emit        = 1'b1;
            ctl.slot_src    = SLOT_IDX;
            ctl.key_src     = KEY_RAM;
            ctl.emit_last   = 1'b1;
            if (sts.func == FUNC_DELETE) begin
              ctl.clr_used    = 1'b1;
              ctl.emit_status = ST_DELETED;
            end else begin
              ctl.emit_status = ST_EXISTS;
            end
            state_next = S_IDLE;
          end
        end else if (sts.idx_last) begin
          state_next = S_FINISH;
        end else begin
          ctl.adv    = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          ctl.emit      = 1'b1;
          ctl.emit_last = 1'b1;
          ctl.slot_src  = SLOT_ZERO;
          ctl.key_src   = KEY_ZERO;
          unique case (sts.func)
            FUNC_CREATE: begin
              if (sts.free_found) begin
                ctl.wr_new      = 1'b1;
                ctl.emit_status = ST_CREATED;
                ctl.slot_src    = SLOT_FREE;
                ctl.key_src     = KEY_CMD;
              end else begin
                ctl.emit_status = ST_FULL;
              end
            end
            FUNC_DELETE: ctl.emit_status = ST_NOTFOUND;
            default:     ctl.emit_status = ST_EMPTY;
          endcase
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (rst) ctl.emit |-> sts.out_free)
    else $error("result word emitted while the result register is held");
  assert property (@(posedge clk) disable iff (rst) ctl.rd |-> sts.used_here)
    else $error("key read issued for an unused slot");
  assert property (@(posedge clk) disable iff (rst) ctl.wr_new |-> sts.free_found)
    else $error("create stored a key without a free slot");

endmodule

### hw/rtl/name_table_insert_delete_list_core.sv
// Top level of the name table core: controller plus datapath.
//
//  channel | valid     | stall     | word      | moves
//  --------+-----------+-----------+-----------+-------------------------------
//  command | cmd_valid | cmd_stall | cmd_word  | func and key, one per command
//  result  | rsp_valid | rsp_stall | rsp_word  | status, slot, entry_key, last
//
// One command is in work at a time; cmd_stall is high from acceptance until
// the command's final result word is loaded into the result register; FUNC_RSVD gives none.
// Create and delete scan the slots in order, reading the key RAM only for
// used slots: an unused slot takes a scan step, a used slot a scan and a
// check step; a match ends the scan early, else a finish step closes it.
// List emits one result word per used slot, or one empty word if none is used.
// Reset clears all used marks at once; the key RAM needs no clearing pass.
// A stall on the result channel holds the scan in place until the result
// register frees up; the next command is accepted while the last result waits.
module name_table_insert_delete_list_core #(
  parameter int SLOTS     = 64,
  parameter int KEY_BYTES = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  ntl_pkg::cmd_word_t cmd_word,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output ntl_pkg::rsp_word_t rsp_word
);
  import ntl_pkg::*;

  ctl_t ctl;
  sts_t sts;
  logic busy;

  // stall commands while one is in work
  assign cmd_stall = busy;

  ntl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .busy     (busy),
    .sts      (sts),
    .ctl      (ctl)
  );

  ntl_dpath #(
    .SLOTS    (SLOTS),
    .KEY_BYTES(KEY_BYTES)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd_word (cmd_word),
    .ctl      (ctl),
    .sts      (sts),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_word (rsp_word)
  );

endmodule
